// ===== rtl/core/imubc_pkg.sv =====
package imubc_pkg;

   // Sample and calibration geometry.
   localparam int AXIS_W          = 16;
   localparam int SUM_W           = 24;
   localparam int COUNT_W         = 8;
   localparam int NUM_AXES        = 6;
   localparam int AXES_PER_GROUP  = 3;
   localparam int CAL_SAMPLES_DEF = 200;

   // Reciprocal used for the end-of-calibration divide: q = (|sum| * R) >> RECIP_SHIFT.
   localparam int RECIP_W     = 32;
   localparam int RECIP_SHIFT = 31;
   localparam int MAG_W       = SUM_W - 1;
   localparam int PROD_W      = MAG_W + RECIP_W;

   // Group indexes for the two calibration groups.
   localparam int GRP_ACC  = 0;
   localparam int GRP_GYRO = 1;

   typedef struct packed {
      logic signed [AXIS_W-1:0] accel_x;
      logic signed [AXIS_W-1:0] accel_y;
      logic signed [AXIS_W-1:0] accel_z;
      logic signed [AXIS_W-1:0] gyro_x;
      logic signed [AXIS_W-1:0] gyro_y;
      logic signed [AXIS_W-1:0] gyro_z;
      logic                     start_gyro_cal;
      logic                     start_acc_cal;
   } req_type;

   typedef struct packed {
      logic signed [AXIS_W-1:0] corr_accel_x;
      logic signed [AXIS_W-1:0] corr_accel_y;
      logic signed [AXIS_W-1:0] corr_accel_z;
      logic signed [AXIS_W-1:0] corr_gyro_x;
      logic signed [AXIS_W-1:0] corr_gyro_y;
      logic signed [AXIS_W-1:0] corr_gyro_z;
      logic                     gyro_cal_busy;
      logic                     acc_cal_busy;
   } rsp_type;

   // Per-cycle commands from a group sequencer to its three lanes.
   typedef struct packed {
      logic clear;   // zero offset and sum (calibration starts)
      logic accum;   // add this sample to the running sum
      logic finish;  // load the divided sum into the offset
   } lane_ctrl_type;

   // Status from a group sequencer to the merge stage.
   typedef struct packed {
      logic busy_next; // calibration still collecting after this request
      logic pending;   // divide in flight, hold off new requests
   } group_stat_type;

endpackage

// ===== rtl/core/imubc_lane.sv =====
module imubc_lane import imubc_pkg::*; #(
   parameter logic [RECIP_W-1:0] CAL_RECIP = RECIP_W'(((64'd1 << RECIP_SHIFT)
                                              + CAL_SAMPLES_DEF - 1) / CAL_SAMPLES_DEF)
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic signed [AXIS_W-1:0] sample,
   input  lane_ctrl_type            ctrl,
   output logic signed [AXIS_W-1:0] corr
);

   logic signed [AXIS_W-1:0] offset_ff, offset_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic [PROD_W-1:0]        prod_ff;
   logic                     neg_ff;
   logic signed [AXIS_W:0]   diff;
   logic signed [SUM_W-1:0]  sum_base;
   logic [SUM_W-1:0]         sum_mag;
   logic [AXIS_W:0]          quot;

   // Correction: raw minus offset, saturated to 16 bits.
   always_comb begin
      diff = {sample[AXIS_W-1], sample} - {offset_ff[AXIS_W-1], offset_ff};
      if (diff[AXIS_W] != diff[AXIS_W-1]) begin
         corr = diff[AXIS_W] ? {1'b1, {(AXIS_W-1){1'b0}}} : {1'b0, {(AXIS_W-1){1'b1}}};
      end else begin
         corr = diff[AXIS_W-1:0];
      end
   end

   // Running sum; a starting request restarts it from its own sample.
   always_comb begin
      sum_base = ctrl.clear ? '0 : sum_ff;
      sum_in   = ctrl.accum ? sum_base + SUM_W'(sample) : sum_base;
   end

   // Divide stage one: magnitude times reciprocal.
   assign sum_mag = sum_ff[SUM_W-1] ? -sum_ff : sum_ff;

   // Divide stage two: shift, restore the sign, truncation toward zero.
   always_comb begin
      quot = prod_ff[RECIP_SHIFT+AXIS_W:RECIP_SHIFT];
      if (ctrl.clear) begin
         offset_in = '0;
      end else if (ctrl.finish) begin
         offset_in = neg_ff ? -quot[AXIS_W-1:0] : quot[AXIS_W-1:0];
      end else begin
         offset_in = offset_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         offset_ff <= '0;
         sum_ff    <= '0;
      end else begin
         offset_ff <= offset_in;
         sum_ff    <= sum_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= PROD_W'(sum_mag[MAG_W-1:0]) * PROD_W'(CAL_RECIP);
      neg_ff  <= sum_ff[SUM_W-1];
   end

endmodule

// ===== rtl/core/imubc_group_ctrl.sv =====
module imubc_group_ctrl import imubc_pkg::*; #(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           start,
   output lane_ctrl_type  ctrl,
   output group_stat_type stat
);

   logic               busy_ff, busy_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic               fin1_ff, fin1_in;
   logic               fin2_ff;
   logic               starting;
   logic               active;
   logic [COUNT_W-1:0] count_inc;

   // Sample counting; the last sample launches the divide (fin1, then fin2).
   always_comb begin
      starting  = accept && start && !busy_ff;
      active    = accept && (busy_ff || starting);
      count_inc = (starting ? '0 : count_ff) + COUNT_W'(1);
      busy_in   = busy_ff;
      count_in  = count_ff;
      fin1_in   = 1'b0;
      if (active) begin
         if (count_inc >= COUNT_W'(CAL_SAMPLES)) begin
            busy_in  = 1'b0;
            count_in = '0;
            fin1_in  = 1'b1;
         end else begin
            busy_in  = 1'b1;
            count_in = count_inc;
         end
      end
      ctrl.clear     = starting;
      ctrl.accum     = active;
      ctrl.finish    = fin2_ff;
      stat.busy_next = busy_in;
      stat.pending   = fin1_ff || fin2_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
         fin1_ff  <= 1'b0;
         fin2_ff  <= 1'b0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
         fin1_ff  <= fin1_in;
         fin2_ff  <= fin1_ff;
      end
   end

endmodule

// ===== rtl/core/imu_bias_calibrate_correct.sv =====
// Channel   Signals                          Direction  Moves
// request   req_valid, req_stall, req_data   in         one six-axis sample, start flags
// response  rsp_valid, rsp_stall, rsp_data   out        corrected sample, busy flags
//
// One request per cycle while req_stall is low, with its response in the next cycle from the output register.
// When a calibration takes its last sample the per-axis divide (reciprocal multiply,
// then shift) runs, and req_stall stays high until the new offsets are loaded.
// Reset clears offsets, sums, counters and the output valid flag; no clearing pass.
// A response held by rsp_stall only blocks a new request if the register is full.
module imu_bias_calibrate_correct import imubc_pkg::*; #(
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam logic [RECIP_W-1:0] CalRecip =
      RECIP_W'(((64'd1 << RECIP_SHIFT) + CAL_SAMPLES - 1) / CAL_SAMPLES);

   logic                     accept;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff;
   logic signed [AXIS_W-1:0] raw  [NUM_AXES];
   logic signed [AXIS_W-1:0] corr [NUM_AXES];
   lane_ctrl_type            grp_ctrl [2];
   group_stat_type           grp_stat [2];

   // Flow control: hold requests while a divide is in flight or the output is blocked.
   assign req_stall = grp_stat[GRP_ACC].pending || grp_stat[GRP_GYRO].pending
                      || (rsp_valid_ff && rsp_stall);
   assign accept    = req_valid && !req_stall;

   assign raw[0] = req_data.accel_x;
   assign raw[1] = req_data.accel_y;
   assign raw[2] = req_data.accel_z;
   assign raw[3] = req_data.gyro_x;
   assign raw[4] = req_data.gyro_y;
   assign raw[5] = req_data.gyro_z;

   // One sequencer per sensor group.
   imubc_group_ctrl #(.CAL_SAMPLES(CAL_SAMPLES)) u_acc_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .start  (req_data.start_acc_cal),
      .ctrl   (grp_ctrl[GRP_ACC]),
      .stat   (grp_stat[GRP_ACC])
   );

   imubc_group_ctrl #(.CAL_SAMPLES(CAL_SAMPLES)) u_gyro_ctrl (
      .clock  (clock),
      .reset  (reset),
      .accept (accept),
      .start  (req_data.start_gyro_cal),
      .ctrl   (grp_ctrl[GRP_GYRO]),
      .stat   (grp_stat[GRP_GYRO])
   );

   // Six axis lanes; the first three follow the accelerometer group.
   for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
      imubc_lane #(.CAL_RECIP(CalRecip)) u_lane (
         .clock  (clock),
         .reset  (reset),
         .sample (raw[i]),
         .ctrl   (grp_ctrl[i / AXES_PER_GROUP]),
         .corr   (corr[i])
      );
   end

   // Merge stage: gather lane results and group status into the output register.
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         rsp_data_ff.corr_accel_x  <= corr[0];
         rsp_data_ff.corr_accel_y  <= corr[1];
         rsp_data_ff.corr_accel_z  <= corr[2];
         rsp_data_ff.corr_gyro_x   <= corr[3];
         rsp_data_ff.corr_gyro_y   <= corr[4];
         rsp_data_ff.corr_gyro_z   <= corr[5];
         rsp_data_ff.gyro_cal_busy <= grp_stat[GRP_GYRO].busy_next;
         rsp_data_ff.acc_cal_busy  <= grp_stat[GRP_ACC].busy_next;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

// ===== tb/imu_bias_calibrate_correct_tb.sv =====
module imu_bias_calibrate_correct_tb import imubc_pkg::*; #(
   // Build with CAL_SAMPLES of 1 to reach the single-sample calibration.
   parameter int CAL_SAMPLES = CAL_SAMPLES_DEF
);

   localparam int TOTAL_ITEMS = 1250;
   localparam int CYCLE_LIMIT = 600000;
   localparam int AXIS_MAX = 32767;
   localparam int AXIS_MIN = -32768;

   logic    clock;
   logic    reset;
   logic    req_valid;
   logic    req_stall;
   req_type req_data;
   logic    rsp_valid;
   logic    rsp_stall;
   rsp_type rsp_data;

   imu_bias_calibrate_correct #(
      .CAL_SAMPLES(CAL_SAMPLES)
   ) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   // Corrected samples still owed by the block, oldest first.
   rsp_type expected_samples[$];
   rsp_type next_expected;

   // Predictor state: per-axis offsets and running sums, per-group counters.
   int bias_offset[NUM_AXES];
   int bias_sum[NUM_AXES];
   int cal_count[2];
   bit cal_busy[2];

   int errors;
   int items_sent;
   int cycle_count;
   bit req_quiet;
   bit rsp_quiet;
   int rsp_hold_left;
   int stall_run;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic int sat_axis(input int v);
      if (v > AXIS_MAX) return AXIS_MAX;
      if (v < AXIS_MIN) return AXIS_MIN;
      return v;
   endfunction

   // Correct one sample with the current offsets, then advance both calibrations.
   function automatic rsp_type predict_correction(input req_type s);
      rsp_type r;
      int raw[NUM_AXES];
      int corr[NUM_AXES];
      int a;
      int g;
      int base;
      bit start;
      raw[0] = s.accel_x;
      raw[1] = s.accel_y;
      raw[2] = s.accel_z;
      raw[3] = s.gyro_x;
      raw[4] = s.gyro_y;
      raw[5] = s.gyro_z;
      for (a = 0; a < NUM_AXES; a++) begin
         corr[a] = sat_axis(raw[a] - bias_offset[a]);
      end
      for (g = 0; g < 2; g++) begin
         base  = (g == GRP_GYRO) ? AXES_PER_GROUP : 0;
         start = (g == GRP_GYRO) ? s.start_gyro_cal : s.start_acc_cal;
         if (start && !cal_busy[g]) begin
            cal_busy[g]  = 1'b1;
            cal_count[g] = 0;
            for (a = base; a < base + AXES_PER_GROUP; a++) begin
               bias_offset[a] = 0;
               bias_sum[a]    = 0;
            end
         end
         if (cal_busy[g]) begin
            for (a = base; a < base + AXES_PER_GROUP; a++) begin
               bias_sum[a] += raw[a];
            end
            cal_count[g] = (cal_count[g] + 1) & 8'hFF;
            // The average truncates toward zero, as signed int division does.
            if (cal_count[g] >= CAL_SAMPLES) begin
               for (a = base; a < base + AXES_PER_GROUP; a++) begin
                  bias_offset[a] = sat_axis(bias_sum[a] / CAL_SAMPLES);
               end
               cal_count[g] = 0;
               cal_busy[g]  = 1'b0;
            end
         end
      end
      r.corr_accel_x  = corr[0][AXIS_W-1:0];
      r.corr_accel_y  = corr[1][AXIS_W-1:0];
      r.corr_accel_z  = corr[2][AXIS_W-1:0];
      r.corr_gyro_x   = corr[3][AXIS_W-1:0];
      r.corr_gyro_y   = corr[4][AXIS_W-1:0];
      r.corr_gyro_z   = corr[5][AXIS_W-1:0];
      r.gyro_cal_busy = cal_busy[GRP_GYRO];
      r.acc_cal_busy  = cal_busy[GRP_ACC];
      return r;
   endfunction

   // Build a sample with each axis spread around its center, clipped to 16 bits.
   function automatic req_type make_sample(input int center[NUM_AXES], input int spread,
                                           input bit start_g, input bit start_a);
      req_type s;
      int v[NUM_AXES];
      int a;
      for (a = 0; a < NUM_AXES; a++) begin
         v[a] = sat_axis(center[a] + int'($urandom_range(0, 2 * spread)) - spread);
      end
      s.accel_x        = v[0][AXIS_W-1:0];
      s.accel_y        = v[1][AXIS_W-1:0];
      s.accel_z        = v[2][AXIS_W-1:0];
      s.gyro_x         = v[3][AXIS_W-1:0];
      s.gyro_y         = v[4][AXIS_W-1:0];
      s.gyro_z         = v[5][AXIS_W-1:0];
      s.start_gyro_cal = start_g;
      s.start_acc_cal  = start_a;
      return s;
   endfunction

   function automatic req_type split_sample(input int acc_v, input int gyro_v,
                                            input bit start_g, input bit start_a);
      int center[NUM_AXES];
      center = '{acc_v, acc_v, acc_v, gyro_v, gyro_v, gyro_v};
      return make_sample(center, 0, start_g, start_a);
   endfunction

   // Mostly back to back, some short gaps, a few long ones.
   function automatic int pick_gap(input bit quiet);
      int r;
      if (quiet) return 0;
      r = $urandom_range(0, 99);
      if (r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Offer one request after a random gap and hold it until accepted.
   task automatic send_sample(input req_type s);
      int gap;
      gap = pick_gap(req_quiet);
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
      @(negedge clock);
      req_valid = 1'b1;
      req_data  = s;
      do @(posedge clock); while (req_stall);
      expected_samples.push_back(predict_correction(s));
      items_sent++;
   endtask

   // Field extremes and alternating bit patterns with zero offsets.
   task automatic test_extremes();
      send_sample(split_sample(AXIS_MAX, AXIS_MIN, 1'b0, 1'b0));
      send_sample(split_sample(AXIS_MIN, AXIS_MAX, 1'b0, 1'b0));
      send_sample(split_sample(0, -1, 1'b0, 1'b0));
      send_sample(split_sample(-1, 0, 1'b0, 1'b0));
      send_sample(split_sample(16'sh5555, -16'sh5556, 1'b0, 1'b0));
      send_sample(split_sample(-16'sh5556, 16'sh5555, 1'b0, 1'b0));
   endtask

   // Start each group, then repeat the starts while the groups are busy.
   task automatic test_start_flags();
      send_sample(split_sample(1000, -1000, 1'b1, 1'b0));
      send_sample(split_sample(1200, -900, 1'b1, 1'b0));
      send_sample(split_sample(-300, 700, 1'b0, 1'b1));
      send_sample(split_sample(-250, 650, 1'b1, 1'b1));
      send_sample(split_sample(40, -40, 1'b0, 1'b1));
   endtask

   // Calibrate onto the extremes, then drive the opposite extremes to saturate.
   task automatic test_saturation();
      int center[NUM_AXES];
      int k;
      center = '{0, 0, 0, 0, 0, 0};
      while (cal_busy[GRP_GYRO] || cal_busy[GRP_ACC]) begin
         send_sample(make_sample(center, 32767, 1'b0, 1'b0));
      end
      for (k = 0; k < CAL_SAMPLES; k++) begin
         send_sample(split_sample(AXIS_MAX, AXIS_MIN, k == 0, k == 0));
      end
      send_sample(split_sample(AXIS_MIN, AXIS_MAX, 1'b0, 1'b0));
      send_sample(split_sample(0, 0, 1'b0, 1'b0));
      send_sample(split_sample(AXIS_MAX, AXIS_MIN, 1'b0, 1'b0));
      send_sample(split_sample(-1, 1, 1'b0, 1'b0));
   endtask

   // The receiver holds off for a long stretch while requests keep coming.
   task automatic test_output_backpressure();
      int center[NUM_AXES];
      int k;
      center    = '{0, 0, 0, 0, 0, 0};
      req_quiet = 1'b1;
      rsp_hold_left = 60;
      for (k = 0; k < 24; k++) begin
         send_sample(make_sample(center, 32767, 1'b0, 1'b0));
      end
      req_quiet = 1'b0;
   endtask

   // Calibration runs with random content and bias, plus noise with stray starts.
   task automatic test_random_traffic();
      int scenario;
      int run_len;
      int spread;
      int k;
      int a;
      int center[NUM_AXES];
      int wide[NUM_AXES];
      bit sg;
      bit sa;
      wide = '{0, 0, 0, 0, 0, 0};
      while (items_sent < TOTAL_ITEMS) begin
         scenario  = $urandom_range(0, 3);
         req_quiet = ($urandom_range(0, 3) == 0);
         rsp_quiet = ($urandom_range(0, 3) == 0);
         for (a = 0; a < NUM_AXES; a++) begin
            case ($urandom_range(0, 3))
               0: begin
                  center[a] = 0;
               end
               1: begin
                  center[a] = int'($urandom_range(0, 65535)) - 32768;
               end
               2: begin
                  center[a] = AXIS_MAX - int'($urandom_range(0, 200));
               end
               default: begin
                  center[a] = AXIS_MIN + int'($urandom_range(0, 200));
               end
            endcase
         end
         case ($urandom_range(0, 3))
            0: spread = 0;
            1: spread = 64;
            2: spread = 4096;
            default: spread = 32767;
         endcase
         if (scenario < 3) begin
            // A full calibration, then a tail checked against the new offsets.
            run_len = CAL_SAMPLES + $urandom_range(5, 40);
            for (k = 0; k < run_len; k++) begin
               if (k == 0) begin
                  sg = (scenario == 0) || (scenario == 1);
                  sa = (scenario == 0) || (scenario == 2);
               end else begin
                  sg = ($urandom_range(0, 39) == 0);
                  sa = ($urandom_range(0, 39) == 0);
               end
               if (k < CAL_SAMPLES) begin
                  send_sample(make_sample(center, spread, sg, sa));
               end else begin
                  send_sample(make_sample(wide, 32767, sg, sa));
               end
            end
         end else begin
            run_len = $urandom_range(10, 40);
            for (k = 0; k < run_len; k++) begin
               sg = ($urandom_range(0, 7) == 0);
               sa = ($urandom_range(0, 7) == 0);
               send_sample(make_sample(wide, 32767, sg, sa));
            end
         end
      end
      req_quiet = 1'b0;
      rsp_quiet = 1'b0;
   endtask

   // Response stall: a forced hold first, then random bursts unless quiet.
   initial begin
      rsp_stall = 1'b0;
      stall_run = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_left > 0) begin
            rsp_stall = 1'b1;
            rsp_hold_left--;
         end else if (stall_run > 0) begin
            rsp_stall = 1'b1;
            stall_run--;
         end else if (rsp_quiet) begin
            rsp_stall = 1'b0;
         end else begin
            case ($urandom_range(0, 19))
               0, 1, 2, 3, 4: begin
                  rsp_stall = 1'b1;
                  stall_run = $urandom_range(0, 2);
               end
               5: begin
                  rsp_stall = 1'b1;
                  stall_run = $urandom_range(8, 30);
               end
               default: begin
                  rsp_stall = 1'b0;
               end
            endcase
         end
      end
   end

   function automatic void check_field(input string name, input logic [AXIS_W-1:0] want,
                                       input logic [AXIS_W-1:0] got);
      if (want !== got) begin
         errors++;
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name,
                  $signed(want), $signed(got));
      end
   endfunction

   // Compare every accepted response with the oldest expected sample.
   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (expected_samples.size() == 0) begin
            errors++;
            $display("%0t: response with no request outstanding, expected none, actual %h",
                     $time, rsp_data);
         end else begin
            next_expected = expected_samples.pop_front();
            check_field("corr_accel_x", next_expected.corr_accel_x, rsp_data.corr_accel_x);
            check_field("corr_accel_y", next_expected.corr_accel_y, rsp_data.corr_accel_y);
            check_field("corr_accel_z", next_expected.corr_accel_z, rsp_data.corr_accel_z);
            check_field("corr_gyro_x", next_expected.corr_gyro_x, rsp_data.corr_gyro_x);
            check_field("corr_gyro_y", next_expected.corr_gyro_y, rsp_data.corr_gyro_y);
            check_field("corr_gyro_z", next_expected.corr_gyro_z, rsp_data.corr_gyro_z);
            check_field("gyro_cal_busy", {{(AXIS_W-1){1'b0}}, next_expected.gyro_cal_busy},
                        {{(AXIS_W-1){1'b0}}, rsp_data.gyro_cal_busy});
            check_field("acc_cal_busy", {{(AXIS_W-1){1'b0}}, next_expected.acc_cal_busy},
                        {{(AXIS_W-1){1'b0}}, rsp_data.acc_cal_busy});
         end
      end
   end

   // Watchdog on the whole run.
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("%0t: timeout after %0d cycles", $time, cycle_count);
         $display("== FAIL ==");
         $finish;
      end
   end

   initial begin
      int a;
      reset         = 1'b1;
      req_valid     = 1'b0;
      req_data      = '0;
      errors        = 0;
      items_sent    = 0;
      cycle_count   = 0;
      req_quiet     = 1'b0;
      rsp_quiet     = 1'b0;
      rsp_hold_left = 0;
      for (a = 0; a < NUM_AXES; a++) begin
         bias_offset[a] = 0;
         bias_sum[a]    = 0;
      end
      cal_count = '{0, 0};
      cal_busy  = '{1'b0, 1'b0};
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_extremes();
      test_start_flags();
      test_saturation();
      test_output_backpressure();
      test_random_traffic();

      @(negedge clock);
      req_valid = 1'b0;
      while (expected_samples.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (errors == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
